>>> rtl/mfle_pkg.sv
// Shared types and constants for the monochrome frame store drawing engine.
// Holds field widths, command codes, controller states and the control/status structs.
// No dependencies.
package mfle_pkg;

  localparam int PIXELS_PER_PAGE = 8;
  localparam int FUNC_W          = 2;
  localparam int COORD_W         = 9;
  localparam int SIZE_W          = 8;
  localparam int DATA_W          = 8;
  localparam int PAGE_W          = 3;
  localparam int COLUMN_W        = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_RECT  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LINE,
    ST_RECT,
    ST_READ,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic line_step;
    logic rect_step;
    logic sweep_step;
    logic read_issue;
    logic load_result;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic line_last;
    logic rect_last;
    logic rect_empty;
    logic sweep_last;
  } status_t;

endpackage

>>> rtl/mfle_if.sv
// Valid/ready channel interfaces for the drawing engine: command in, response out.
// Depends on mfle_pkg for field widths.
interface mfle_cmd_if import mfle_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [COORD_W-1:0]  x_start;
  logic signed [COORD_W-1:0]  y_start;
  logic signed [COORD_W-1:0]  x_end;
  logic signed [COORD_W-1:0]  y_end;
  logic [SIZE_W-1:0]          rect_width;
  logic [SIZE_W-1:0]          rect_height;
  logic                       color;
  logic [PAGE_W-1:0]          read_page;
  logic [COLUMN_W-1:0]        read_column;

  modport source (
    output valid, func, x_start, y_start, x_end, y_end, rect_width, rect_height,
           color, read_page, read_column,
    input  ready
  );
  modport sink (
    input  valid, func, x_start, y_start, x_end, y_end, rect_width, rect_height,
           color, read_page, read_column,
    output ready
  );
endinterface

interface mfle_rsp_if import mfle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

>>> rtl/mono_framebuffer_line_engine.sv
// Drawing engine for a paged monochrome frame store: clear, Bresenham line,
// rectangle fill and byte read. One command in flight; each gives one response.
// Pixels are drawn one per cycle by a read-modify-write through the frame store's
// read port and write port. Reset sweeps the store to zero with cmd.ready low.
module mono_framebuffer_line_engine import mfle_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  mfle_cmd_if.sink   cmd,
  mfle_rsp_if.source rsp
);

  // Command/status between sequencer and datapath
  ctl_t    ctl;
  status_t status;

  // The sequencer owns the handshake: it takes a command transaction only when idle
  // and holds the response until the downstream transaction completes.
  mfle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .func      (cmd.func),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .ctl       (ctl)
  );

  // The datapath latches the command fields on load, walks pixels, owns the store
  // and the response data register.
  mfle_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .status      (status),
    .func        (cmd.func),
    .x_start     (cmd.x_start),
    .y_start     (cmd.y_start),
    .x_end       (cmd.x_end),
    .y_end       (cmd.y_end),
    .rect_width  (cmd.rect_width),
    .rect_height (cmd.rect_height),
    .color       (cmd.color),
    .read_page   (cmd.read_page),
    .read_column (cmd.read_column),
    .read_data   (rsp.read_data)
  );

endmodule

>>> rtl/mfle_ctrl.sv
// Command sequencer for the drawing engine: state machine and response valid flag.
// Depends on mfle_pkg (state_t, ctl_t, status_t, command codes).
module mfle_ctrl import mfle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  output logic              out_valid,
  input  logic              out_ready,
  input  status_t           status,
  output ctl_t              ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_LINE:  state_next = ST_LINE;
            FUNC_RECT:  state_next = ST_RECT;
            default:    state_next = ST_READ;
          endcase
        end
      end
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_RESP;
      end
      ST_LINE: begin
        if (status.line_last) state_next = ST_DRAIN;
      end
      ST_RECT: begin
        if (status.rect_last || status.rect_empty) state_next = ST_DRAIN;
      end
      ST_READ:  state_next = ST_RESP;
      ST_DRAIN: state_next = ST_RESP;
      ST_RESP: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      ST_INIT:  ctl.sweep_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_CLEAR: ctl.sweep_step = 1'b1;
      ST_LINE:  ctl.line_step  = 1'b1;
      ST_RECT:  ctl.rect_step  = 1'b1;
      ST_READ:  ctl.read_issue = 1'b1;
      ST_RESP:  ctl.load_result = !out_valid || out_ready;
      default:  ctl = '0;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("command accepted but sequencer stayed idle");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RESP))
    else $error("response raised outside the response state");

  a_resp_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && out_valid && !out_ready) |=> (state == ST_RESP))
    else $error("response state left while previous response still stalled");

endmodule

>>> rtl/mfle_datapath.sv
// Datapath for the drawing engine: line walker, rectangle scanner, clear sweep,
// frame store memory with a two-stage pixel read-modify-write pipe, response register.
// Depends on mfle_pkg (ctl_t, status_t, widths, command codes).
module mfle_datapath import mfle_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctl_t                      ctl,
  output status_t                   status,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [COORD_W-1:0] x_start,
  input  logic signed [COORD_W-1:0] y_start,
  input  logic signed [COORD_W-1:0] x_end,
  input  logic signed [COORD_W-1:0] y_end,
  input  logic [SIZE_W-1:0]         rect_width,
  input  logic [SIZE_W-1:0]         rect_height,
  input  logic                      color,
  input  logic [PAGE_W-1:0]         read_page,
  input  logic [COLUMN_W-1:0]       read_column,
  output logic [DATA_W-1:0]         read_data
);

  localparam int PAGES = (SCREEN_HEIGHT + PIXELS_PER_PAGE - 1) / PIXELS_PER_PAGE;
  localparam int DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [11:0] SCR_W = 12'(SCREEN_WIDTH);
  localparam logic signed [11:0] SCR_H = 12'(SCREEN_HEIGHT);

  // Command registers
  logic [FUNC_W-1:0]  op;
  logic               paint;
  logic signed [9:0]  walk_x, walk_y;
  logic signed [9:0]  end_x, end_y;
  logic signed [11:0] walk_error, delta_x, delta_y;
  logic               step_x_up, step_y_up;
  logic signed [9:0]  rect_y_lo, rect_x_last, rect_y_last;
  logic               rect_empty;
  logic [AW-1:0]      read_addr;
  logic               read_ok;
  logic [AW-1:0]      sweep_addr;

  // Setup arithmetic from the incoming command
  logic signed [11:0] xs, ys, xe, ye, diff_x, diff_y, abs_dx, neg_dy;
  logic signed [11:0] rx_lo, ry_lo, rx_hi_raw, ry_hi_raw, rx_hi, ry_hi;

  always_comb begin
    xs        = $signed({{3{x_start[COORD_W-1]}}, x_start});
    ys        = $signed({{3{y_start[COORD_W-1]}}, y_start});
    xe        = $signed({{3{x_end[COORD_W-1]}}, x_end});
    ye        = $signed({{3{y_end[COORD_W-1]}}, y_end});
    diff_x    = xe - xs;
    diff_y    = ye - ys;
    abs_dx    = diff_x[11] ? -diff_x : diff_x;
    neg_dy    = diff_y[11] ? diff_y : -diff_y;
    rx_lo     = xs[11] ? 12'sd0 : xs;
    ry_lo     = ys[11] ? 12'sd0 : ys;
    rx_hi_raw = xs + $signed({4'b0000, rect_width});
    ry_hi_raw = ys + $signed({4'b0000, rect_height});
    rx_hi     = (rx_hi_raw > SCR_W) ? SCR_W : rx_hi_raw;
    ry_hi     = (ry_hi_raw > SCR_H) ? SCR_H : ry_hi_raw;
  end

  // Bresenham step
  logic signed [12:0] err_dbl, dx13, dy13;
  logic               go_x, go_y;
  logic signed [11:0] error_next;

  always_comb begin
    err_dbl    = $signed({walk_error, 1'b0});
    dx13       = $signed({delta_x[11], delta_x});
    dy13       = $signed({delta_y[11], delta_y});
    go_x       = err_dbl >= dy13;
    go_y       = err_dbl <= dx13;
    error_next = walk_error + (go_x ? delta_y : 12'sd0) + (go_y ? delta_x : 12'sd0);
  end

  assign status.line_last  = (walk_x == end_x) && (walk_y == end_y);
  assign status.rect_last  = (walk_x == rect_x_last) && (walk_y == rect_y_last);
  assign status.rect_empty = rect_empty;
  assign status.sweep_last = (sweep_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op        <= func;
      paint     <= color;
      end_x     <= xe[9:0];
      end_y     <= ye[9:0];
      delta_x   <= abs_dx;
      delta_y   <= neg_dy;
      step_x_up <= xs < xe;
      step_y_up <= ys < ye;
      rect_y_lo   <= ry_lo[9:0];
      rect_x_last <= 10'(rx_hi - 12'sd1);
      rect_y_last <= 10'(ry_hi - 12'sd1);
      rect_empty  <= (rx_lo >= rx_hi) || (ry_lo >= ry_hi);
      read_ok   <= (32'(read_page) < PAGES) && (32'(read_column) < SCREEN_WIDTH);
      read_addr <= AW'(32'(read_page) * SCREEN_WIDTH + 32'(read_column));
      if (func == FUNC_RECT) begin
        walk_x <= rx_lo[9:0];
        walk_y <= ry_lo[9:0];
      end else begin
        walk_x <= xs[9:0];
        walk_y <= ys[9:0];
      end
      walk_error <= abs_dx + neg_dy;
    end else if (ctl.line_step && !status.line_last) begin
      walk_error <= error_next;
      if (go_x) walk_x <= step_x_up ? walk_x + 10'sd1 : walk_x - 10'sd1;
      if (go_y) walk_y <= step_y_up ? walk_y + 10'sd1 : walk_y - 10'sd1;
    end else if (ctl.rect_step && !rect_empty && !status.rect_last) begin
      if (walk_y == rect_y_last) begin
        walk_y <= rect_y_lo;
        walk_x <= walk_x + 10'sd1;
      end else begin
        walk_y <= walk_y + 10'sd1;
      end
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      sweep_addr <= '0;
    end else if (ctl.sweep_step) begin
      sweep_addr <= status.sweep_last ? '0 : sweep_addr + AW'(1);
    end
  end

  // Pixel stage A: clip and address
  logic          on_screen, pix_on;
  logic [AW-1:0] pix_addr;

  always_comb begin
    on_screen = !walk_x[9] && (walk_x[8:0] < 9'(SCREEN_WIDTH)) &&
                !walk_y[9] && (walk_y[8:0] < 9'(SCREEN_HEIGHT));
    pix_on    = (ctl.line_step || (ctl.rect_step && !rect_empty)) && on_screen;
    pix_addr  = AW'(32'(walk_y[8:3]) * SCREEN_WIDTH + 32'(walk_x[8:0]));
  end

  // Frame store
  logic [DATA_W-1:0] store [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Pixel stage B and write forwarding
  logic              wr_pend;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_mask;
  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  logic [DATA_W-1:0] fwd_data;
  logic [DATA_W-1:0] base, merged;

  always_comb begin
    base      = (fwd_valid && (fwd_addr == wr_addr)) ? fwd_data : mem_q;
    merged    = paint ? (base | wr_mask) : (base & ~wr_mask);
    mem_re    = pix_on || ctl.read_issue;
    mem_raddr = ctl.read_issue ? read_addr : pix_addr;
    mem_we    = wr_pend || ctl.sweep_step;
    mem_waddr = ctl.sweep_step ? sweep_addr : wr_addr;
    mem_wdata = ctl.sweep_step ? '0 : merged;
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      wr_pend   <= pix_on;
      fwd_valid <= wr_pend;
    end
    wr_addr  <= pix_addr;
    wr_mask  <= DATA_W'(1) << walk_y[2:0];
    fwd_addr <= wr_addr;
    fwd_data <= merged;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      read_data <= (op == FUNC_READ && read_ok) ? mem_q : '0;
    end
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(wr_pend && ctl.sweep_step))
    else $error("pixel write collides with clear sweep");

  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (32'(wr_addr) < DEPTH))
    else $error("pixel write beyond frame store");

  a_zero_for_draw: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_result && op != FUNC_READ) |=> (read_data == '0))
    else $error("non-read command returned nonzero data");

endmodule

>>> tb/tb_mono_framebuffer_line_engine.sv
// Self-checking testbench for the paged monochrome frame store drawing engine.
// Depends on mfle_pkg, the mfle_cmd_if/mfle_rsp_if interfaces and the engine RTL.
// A shadow frame store predicts every response byte; a scoreboard class compares them.
module tb_mono_framebuffer_line_engine;
  import mfle_pkg::*;

  localparam int SCREEN_W     = 128;
  localparam int SCREEN_H     = 64;
  localparam int PAGES        = SCREEN_H / PIXELS_PER_PAGE;
  localparam int STORE_SIZE   = SCREEN_W * PAGES;
  localparam int RANDOM_ITEMS = 1875;
  // Worst case per command: a full-screen rectangle plus the longest
  // sender gap and the longest response stall, over every command, at 4 units per
  // cycle, then taken about four times over.
  localparam int RUN_LIMIT    = 250_000_000;

  // One drawing command as the sender sees it.
  typedef struct {
    func_t                     func;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic [SIZE_W-1:0]         rect_width;
    logic [SIZE_W-1:0]         rect_height;
    logic                      color;
    logic [PAGE_W-1:0]         read_page;
    logic [COLUMN_W-1:0]       read_column;
  } draw_cmd_t;

  // Shadow frame store plus the queue of response bytes still owed by the engine.
  class frame_scoreboard;
    bit [DATA_W-1:0] shadow [STORE_SIZE];
    bit [DATA_W-1:0] owed_bytes [$];
    int unsigned     mismatches;
    int unsigned     responses;
    int unsigned     nonzero_reads;
    int unsigned     func_count [4];

    function new();
      wipe();
    endfunction

    function void wipe();
      foreach (shadow[i]) shadow[i] = '0;
    endfunction

    function void plot_pixel(int x, int y, bit lit);
      int idx;
      if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
      idx = (y / PIXELS_PER_PAGE) * SCREEN_W + x;
      shadow[idx][y % PIXELS_PER_PAGE] = lit;
    endfunction

    function void walk_line(int x0, int y0, int x1, int y1, bit lit);
      int dx, dy, sx, sy, err, e2, x, y;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y0 - y1 : y1 - y0;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      x = x0;
      y = y0;
      forever begin
        plot_pixel(x, y, lit);
        if (x == x1 && y == y1) break;
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          x += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          y += sy;
        end
      end
    endfunction

    function void fill_rect(int x, int y, int w, int h, bit lit);
      int x_lo, y_lo, x_hi, y_hi;
      x_lo = (x < 0) ? 0 : x;
      y_lo = (y < 0) ? 0 : y;
      x_hi = (x + w > SCREEN_W) ? SCREEN_W : x + w;
      y_hi = (y + h > SCREEN_H) ? SCREEN_H : y + h;
      for (int i = x_lo; i < x_hi; i++)
        for (int j = y_lo; j < y_hi; j++)
          plot_pixel(i, j, lit);
    endfunction

    function void note_command(draw_cmd_t c);
      bit [DATA_W-1:0] byte_out;
      byte_out = '0;
      func_count[c.func]++;
      case (c.func)
        FUNC_CLEAR: wipe();
        FUNC_LINE:  walk_line(int'(c.x_start), int'(c.y_start), int'(c.x_end),
                              int'(c.y_end), c.color);
        FUNC_RECT:  fill_rect(int'(c.x_start), int'(c.y_start), int'(c.rect_width),
                              int'(c.rect_height), c.color);
        FUNC_READ: begin
          if (c.read_page < PAGES && c.read_column < SCREEN_W)
            byte_out = shadow[c.read_page * SCREEN_W + c.read_column];
          if (byte_out != 0) nonzero_reads++;
        end
        default: ;
      endcase
      owed_bytes.push_back(byte_out);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at response %0d: %s", responses, what);
    endtask

    task check_result(logic [DATA_W-1:0] got);
      bit [DATA_W-1:0] want;
      if (owed_bytes.size() == 0) begin
        report($sformatf("read_data %02h arrived with no command outstanding", got));
      end else begin
        want = owed_bytes.pop_front();
        if (got !== want)
          report($sformatf("read_data got %02h want %02h", got, want));
      end
      responses++;
    endtask

    function int pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  logic steady = 1'b0;   // high: no idling on either side for a stretch
  int   ready_hold = 0;
  int   last_x = 0;
  int   last_y = 0;

  frame_scoreboard sb = new();

  mfle_cmd_if cmd_ch ();
  mfle_rsp_if rsp_ch ();

  assign rsp_ch.ready = sink_ready;

  mono_framebuffer_line_engine DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the engine hangs or never returns a response.
  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d responses still outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // Most idle stretches are short, a few are long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response side: hold ready high or low for random stretches; never stall in a
  // steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      ready_hold <= 0;
    end else if (steady) begin
      sink_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      sink_ready <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_idle();
    end
  end

  // Sample each response transaction with the values present at the edge.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.read_data);
  end

  function automatic draw_cmd_t make_cmd(func_t f, int xs, int ys, int xe, int ye,
                                         int w, int h, int lit, int page, int column);
    draw_cmd_t c;
    c.func        = f;
    c.x_start     = COORD_W'(xs);
    c.y_start     = COORD_W'(ys);
    c.x_end       = COORD_W'(xe);
    c.y_end       = COORD_W'(ye);
    c.rect_width  = SIZE_W'(w);
    c.rect_height = SIZE_W'(h);
    c.color       = (lit != 0);
    c.read_page   = PAGE_W'(page);
    c.read_column = COLUMN_W'(column);
    return c;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Mostly near the screen; now and then anywhere in the signed 9-bit range.
  function automatic int pick_coord(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 511)) - 256;
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int r, sz;
    r = $urandom_range(0, 99);
    // Start from fully random fields so unused ones toggle too.
    c = make_cmd(FUNC_READ, int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
                 int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 7), $urandom_range(0, 127));
    if (r < 2) begin
      c.func = FUNC_CLEAR;
    end else if (r < 42) begin
      c.func    = FUNC_LINE;
      c.color   = ($urandom_range(0, 3) != 0);
      c.x_start = COORD_W'(pick_coord(-16, SCREEN_W + 15));
      c.y_start = COORD_W'(pick_coord(-16, SCREEN_H + 15));
      // Short strokes are common; some run across the whole screen.
      if ($urandom_range(0, 2) == 0) begin
        c.x_end = COORD_W'(pick_coord(-16, SCREEN_W + 15));
        c.y_end = COORD_W'(pick_coord(-16, SCREEN_H + 15));
      end else begin
        c.x_end = COORD_W'(int'(c.x_start) + int'($urandom_range(0, 24)) - 12);
        c.y_end = COORD_W'(int'(c.y_start) + int'($urandom_range(0, 24)) - 12);
      end
      last_x = clamp(int'(c.x_end), 0, SCREEN_W - 1);
      last_y = clamp(int'(c.y_end), 0, SCREEN_H - 1);
    end else if (r < 62) begin
      c.func    = FUNC_RECT;
      c.color   = ($urandom_range(0, 3) != 0);
      c.x_start = COORD_W'(pick_coord(-16, SCREEN_W + 7));
      c.y_start = COORD_W'(pick_coord(-16, SCREEN_H + 7));
      // Keep most fills small; big ones can cover up to the whole screen.
      sz = $urandom_range(0, 99);
      if (sz < 80) begin
        c.rect_width  = SIZE_W'($urandom_range(0, 20));
        c.rect_height = SIZE_W'($urandom_range(0, 20));
      end else if (sz < 95) begin
        c.rect_width  = SIZE_W'($urandom_range(0, 48));
        c.rect_height = SIZE_W'($urandom_range(0, 48));
      end
      last_x = clamp(int'(c.x_start), 0, SCREEN_W - 1);
      last_y = clamp(int'(c.y_start), 0, SCREEN_H - 1);
    end else begin
      c.func = FUNC_READ;
      // Aim half of the reads at the most recent drawing.
      if ($urandom_range(0, 1) == 0) begin
        c.read_page   = PAGE_W'(last_y / PIXELS_PER_PAGE);
        c.read_column = COLUMN_W'(clamp(last_x + int'($urandom_range(0, 6)) - 3, 0,
                                        SCREEN_W - 1));
      end
    end
    return c;
  endfunction

  // Present one command after a random gap and hold it until the engine takes it.
  // Enter at an edge; valid is changed at most once in that time step.
  task automatic send_cmd(draw_cmd_t c);
    int gap;
    gap = steady ? 0 : pick_idle();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= c.func;
    cmd_ch.x_start     <= c.x_start;
    cmd_ch.y_start     <= c.y_start;
    cmd_ch.x_end       <= c.x_end;
    cmd_ch.y_end       <= c.y_end;
    cmd_ch.rect_width  <= c.rect_width;
    cmd_ch.rect_height <= c.rect_height;
    cmd_ch.color       <= c.color;
    cmd_ch.read_page   <= c.read_page;
    cmd_ch.read_column <= c.read_column;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_command(c);
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= FUNC_CLEAR;
    cmd_ch.x_start     <= '0;
    cmd_ch.y_start     <= '0;
    cmd_ch.x_end       <= '0;
    cmd_ch.y_end       <= '0;
    cmd_ch.rect_width  <= '0;
    cmd_ch.rect_height <= '0;
    cmd_ch.color       <= 1'b0;
    cmd_ch.read_page   <= '0;
    cmd_ch.read_column <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The engine sweeps its store after reset with ready low; the
    // first send simply waits that out.
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));         // store reads zero
    send_cmd(make_cmd(FUNC_LINE, -256, -256, 255, 255, 0, 0, 1, 0, 0)); // diagonal, clipped
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_LINE, 127, 63, 127, 63, 0, 0, 1, 0, 0));    // single point
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 7, 127));
    send_cmd(make_cmd(FUNC_LINE, -20, 5, 140, 5, 0, 0, 1, 0, 0));      // horizontal
    send_cmd(make_cmd(FUNC_LINE, 64, -10, 64, 70, 0, 0, 1, 0, 0));     // vertical
    send_cmd(make_cmd(FUNC_LINE, -256, 100, -1, 255, 0, 0, 1, 0, 0));  // wholly off screen
    send_cmd(make_cmd(FUNC_LINE, 3, 0, 10, 63, 0, 0, 1, 0, 0));        // steep
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64));
    send_cmd(make_cmd(FUNC_RECT, 10, 10, 0, 0, 0, 20, 1, 0, 0));       // zero width
    send_cmd(make_cmd(FUNC_RECT, 10, 10, 0, 0, 20, 0, 1, 0, 0));       // zero height
    send_cmd(make_cmd(FUNC_RECT, -256, -256, 0, 0, 255, 255, 1, 0, 0)); // ends left of screen
    send_cmd(make_cmd(FUNC_RECT, 120, 60, 0, 0, 255, 255, 1, 0, 0));  // clipped corner
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 7, 125));
    send_cmd(make_cmd(FUNC_RECT, 0, 0, 0, 0, 255, 255, 0, 0, 0));      // erase whole screen
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 64));
    send_cmd(make_cmd(FUNC_RECT, -5, -5, 0, 0, 10, 10, 1, 0, 0));      // negative origin
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_LINE, 255, -256, -256, 255, 0, 0, 1, 0, 0)); // longest walk
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 3, 60));
    send_cmd(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 3, 60));
    send_cmd(make_cmd(FUNC_LINE, 0, 0, 127, 63, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(FUNC_LINE, 0, 0, 127, 63, 0, 0, 0, 0, 0));       // same line erased

    // Random part, alternating between idling stretches and steady stretches.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= ((i / 160) % 3 == 1);
      send_cmd(random_cmd());
    end
    cmd_ch.valid <= 1'b0;

    // Drain outstanding responses, then watch a little longer for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("run covered %0d clears, %0d lines, %0d rectangles, %0d reads (%0d nonzero)",
             sb.func_count[FUNC_CLEAR], sb.func_count[FUNC_LINE], sb.func_count[FUNC_RECT],
             sb.func_count[FUNC_READ], sb.nonzero_reads);
    $display("%0d responses compared, %0d mismatches", sb.responses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
